@@ src/tbfa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the two-map free-bit allocator: sizes, field widths, codes and
// the request and response payload types. It depends on nothing else.
package tbfa_pkg;

  localparam int unsigned INODE_BITS = 1024;
  localparam int unsigned BLOCK_BITS = 8192;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_IW = $clog2(WORD_W);

  localparam int unsigned INODE_WORDS = INODE_BITS / WORD_W;
  localparam int unsigned BLOCK_WORDS = BLOCK_BITS / WORD_W;
  localparam int unsigned INODE_AW    = $clog2(INODE_WORDS);
  localparam int unsigned BLOCK_AW    = $clog2(BLOCK_WORDS);
  localparam int unsigned WORD_AW     = (BLOCK_AW > INODE_AW) ? BLOCK_AW : INODE_AW;

  localparam int unsigned INODE_FIND_START = 10;
  localparam int unsigned BLOCK_FIND_START = 1;
  localparam int unsigned INODE_START_WORD = INODE_FIND_START / WORD_W;
  localparam int unsigned BLOCK_START_WORD = BLOCK_FIND_START / WORD_W;
  localparam int unsigned INODE_START_LO   = INODE_FIND_START % WORD_W;
  localparam int unsigned BLOCK_START_LO   = BLOCK_FIND_START % WORD_W;

  localparam int unsigned INODE_TOTAL_W = 11;
  localparam int unsigned BLOCK_TOTAL_W = 14;
  localparam int unsigned INDEX_W       = 13;
  localparam int unsigned NUM_W         = 14;

  localparam int unsigned INODE_TOTAL_RST = 1024;
  localparam int unsigned BLOCK_TOTAL_RST = 8192;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_SET    = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_PRESET = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_INODE_TOTAL = 1'b0,
    CFG_BLOCK_TOTAL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    mode_e                    mode;
    logic                     map_select;
    logic [INDEX_W-1:0]       bit_index;
    logic [BLOCK_TOTAL_W-1:0] count_value;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [NUM_W-1:0]         free_number;
    logic [INODE_TOTAL_W-1:0] free_inodes;
    logic [BLOCK_TOTAL_W-1:0] free_blocks;
  } rsp_t;

endpackage

@@ src/tbfa_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the allocator's request and response.
// They depend on the payload types in tbfa_pkg.
interface tbfa_req_if;
  logic          valid;
  logic          ready;
  tbfa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tbfa_rsp_if;
  logic          valid;
  logic          ready;
  tbfa_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/two_bitmap_free_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the two-map free-bit allocator: word-wide map memories, free
// counters, totals and the request sequencer. Depends on tbfa_pkg and tbfa_if.
//
//   port       dir   kind        payload
//   req_i      in    valid/ready mode, map_select, bit_index, count_value
//   rsp_o      out   valid/ready found, free_number, free_inodes, free_blocks
//   cfg_*_i    in    write only  inode_total, block_total
//
// A set, clear or preset request reads its map word on acceptance and has its result
// registered from the evaluate state. A find reads and checks one 64-bit map word at a time,
// up to 16 words of the inode map and 128 of the block map, through the single read port of
// each map memory. The sequencer takes no new request until the result is registered.
// Reset marks every map word as clear at once through per-word valid flops. A finished
// request waits in the sequencer while the output register still holds an unread result.
module two_bitmap_free_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  tbfa_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [tbfa_pkg::BLOCK_TOTAL_W-1:0] cfg_wdata_i,
  tbfa_req_if.sink                           req_i,
  tbfa_rsp_if.source                         rsp_o
);
  import tbfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  localparam logic [WORD_W-1:0] One = {{(WORD_W-1){1'b0}}, 1'b1};

  state_e                   state_q, state_d;
  req_t                     req_q;
  logic [WORD_AW-1:0]       word_q, word_d;
  logic [WORD_AW-1:0]       raddr;
  logic                     rd_en;

  logic [WORD_W-1:0]        inode_mem_q [INODE_WORDS];
  logic [WORD_W-1:0]        block_mem_q [BLOCK_WORDS];
  logic [INODE_WORDS-1:0]   inode_vld_q;
  logic [BLOCK_WORDS-1:0]   block_vld_q;
  logic [WORD_W-1:0]        inode_rd_q, block_rd_q;
  logic                     inode_rv_q, block_rv_q;

  logic [INODE_TOTAL_W-1:0] inode_total_q;
  logic [BLOCK_TOTAL_W-1:0] block_total_q;
  logic [INODE_TOTAL_W-1:0] inode_cnt_q, inode_cnt_d;
  logic [BLOCK_TOTAL_W-1:0] block_cnt_q, block_cnt_d;

  rsp_t                     rsp_q, rsp_d;
  logic                     rsp_vld_q, rsp_vld_d;

  logic                     accept, slot_free, commit, wr_en, sel_blk, idx_ok;
  logic [WORD_W-1:0]        cur_word, new_word, bit_sel;
  logic [WORD_W-1:0]        hi_mask, lo_mask, free_vec;
  logic [INODE_TOTAL_W-1:0] inode_lim;
  logic [BLOCK_TOTAL_W-1:0] block_lim;
  logic [NUM_W-1:0]         lim, base, next_base, lim_rel, find_num;
  logic [WORD_AW-1:0]       st_word;
  logic [WORD_IW-1:0]       st_lo, hit_pos;
  logic                     hit, find_done, done;
  logic [INODE_TOTAL_W-1:0] inode_dec, inode_inc, inode_pre;
  logic [BLOCK_TOTAL_W-1:0] block_dec, block_inc, block_pre;

  assign accept      = (state_q == ST_IDLE) && req_i.valid;
  assign req_i.ready = (state_q == ST_IDLE);
  assign slot_free   = !rsp_vld_q || rsp_o.ready;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    sel_blk  = req_q.map_select;
    cur_word = sel_blk ? (block_rv_q ? block_rd_q : '0) : (inode_rv_q ? inode_rd_q : '0);

    inode_lim = {inode_total_q[INODE_TOTAL_W-1:3], 3'b000};
    if (inode_lim > INODE_TOTAL_W'(INODE_BITS)) begin
      inode_lim = INODE_TOTAL_W'(INODE_BITS);
    end
    block_lim = {block_total_q[BLOCK_TOTAL_W-1:3], 3'b000};
    if (block_lim > BLOCK_TOTAL_W'(BLOCK_BITS)) begin
      block_lim = BLOCK_TOTAL_W'(BLOCK_BITS);
    end
    lim = sel_blk ? NUM_W'(block_lim) : NUM_W'(inode_lim);

    st_word = sel_blk ? WORD_AW'(BLOCK_START_WORD) : WORD_AW'(INODE_START_WORD);
    st_lo   = sel_blk ? WORD_IW'(BLOCK_START_LO) : WORD_IW'(INODE_START_LO);

    base      = NUM_W'({word_q, {WORD_IW{1'b0}}});
    next_base = base + NUM_W'(WORD_W);
    lim_rel   = lim - base;
    hi_mask   = (lim_rel >= NUM_W'(WORD_W)) ? '1 : ((One << lim_rel[WORD_IW-1:0]) - One);
    lo_mask   = (word_q == st_word) ? ~((One << st_lo) - One) : '1;
    free_vec  = ~cur_word & hi_mask & lo_mask;

    hit     = |free_vec;
    hit_pos = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        hit_pos = WORD_IW'(k);
      end
    end
    find_num  = base + NUM_W'(hit_pos) + NUM_W'(1);
    find_done = hit || (next_base >= lim);
    done      = (req_q.mode != MODE_FIND) || find_done;
  end

  always_comb begin
    idx_ok   = sel_blk ? (32'(req_q.bit_index) < BLOCK_BITS)
                       : (32'(req_q.bit_index) < INODE_BITS);
    bit_sel  = One << req_q.bit_index[WORD_IW-1:0];
    new_word = (req_q.mode == MODE_SET) ? (cur_word | bit_sel) : (cur_word & ~bit_sel);

    inode_dec = (inode_cnt_q != '0) ? inode_cnt_q - INODE_TOTAL_W'(1) : inode_cnt_q;
    inode_inc = (inode_cnt_q < inode_total_q) ? inode_cnt_q + INODE_TOTAL_W'(1) : inode_cnt_q;
    inode_pre = (req_q.count_value > BLOCK_TOTAL_W'(inode_total_q)) ? inode_total_q
              : req_q.count_value[INODE_TOTAL_W-1:0];
    block_dec = (block_cnt_q != '0) ? block_cnt_q - BLOCK_TOTAL_W'(1) : block_cnt_q;
    block_inc = (block_cnt_q < block_total_q) ? block_cnt_q + BLOCK_TOTAL_W'(1) : block_cnt_q;
    block_pre = (req_q.count_value > block_total_q) ? block_total_q : req_q.count_value;

    inode_cnt_d = inode_cnt_q;
    block_cnt_d = block_cnt_q;
    unique case (req_q.mode)
      MODE_SET: begin
        if (idx_ok && !sel_blk) inode_cnt_d = inode_dec;
        if (idx_ok && sel_blk)  block_cnt_d = block_dec;
      end
      MODE_CLEAR: begin
        if (idx_ok && !sel_blk) inode_cnt_d = inode_inc;
        if (idx_ok && sel_blk)  block_cnt_d = block_inc;
      end
      MODE_PRESET: begin
        if (!sel_blk) inode_cnt_d = inode_pre;
        if (sel_blk)  block_cnt_d = block_pre;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    rd_en     = 1'b0;
    raddr     = word_q;
    commit    = 1'b0;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (req_i.payload.mode == MODE_FIND) begin
            raddr = req_i.payload.map_select ? WORD_AW'(BLOCK_START_WORD)
                                             : WORD_AW'(INODE_START_WORD);
          end else begin
            raddr = WORD_AW'(req_i.payload.bit_index >> WORD_IW);
          end
          word_d  = raddr;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!done) begin
          rd_en  = 1'b1;
          raddr  = word_q + WORD_AW'(1);
          word_d = raddr;
        end else if (slot_free) begin
          commit                = 1'b1;
          rsp_vld_d             = 1'b1;
          rsp_d.found           = (req_q.mode == MODE_FIND) && hit;
          rsp_d.free_number     = ((req_q.mode == MODE_FIND) && hit) ? find_num : '0;
          rsp_d.free_inodes     = inode_cnt_d;
          rsp_d.free_blocks     = block_cnt_d;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr_en = commit && idx_ok &&
                 ((req_q.mode == MODE_SET) || (req_q.mode == MODE_CLEAR));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      inode_rd_q <= inode_mem_q[raddr[INODE_AW-1:0]];
      block_rd_q <= block_mem_q[raddr[BLOCK_AW-1:0]];
    end
    if (wr_en && !sel_blk) begin
      inode_mem_q[word_q[INODE_AW-1:0]] <= new_word;
    end
    if (wr_en && sel_blk) begin
      block_mem_q[word_q[BLOCK_AW-1:0]] <= new_word;
    end
    if (accept) begin
      req_q <= req_i.payload;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      word_q        <= '0;
      inode_vld_q   <= '0;
      block_vld_q   <= '0;
      inode_rv_q    <= 1'b0;
      block_rv_q    <= 1'b0;
      inode_cnt_q   <= '0;
      block_cnt_q   <= '0;
      inode_total_q <= INODE_TOTAL_W'(INODE_TOTAL_RST);
      block_total_q <= BLOCK_TOTAL_W'(BLOCK_TOTAL_RST);
      rsp_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      word_q    <= word_d;
      rsp_vld_q <= rsp_vld_d;
      if (rd_en) begin
        inode_rv_q <= inode_vld_q[raddr[INODE_AW-1:0]];
        block_rv_q <= block_vld_q[raddr[BLOCK_AW-1:0]];
      end
      if (wr_en && !sel_blk) begin
        inode_vld_q[word_q[INODE_AW-1:0]] <= 1'b1;
      end
      if (wr_en && sel_blk) begin
        block_vld_q[word_q[BLOCK_AW-1:0]] <= 1'b1;
      end
      if (commit) begin
        inode_cnt_q <= inode_cnt_d;
        block_cnt_q <= block_cnt_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INODE_TOTAL: inode_total_q <= cfg_wdata_i[INODE_TOTAL_W-1:0];
          CFG_BLOCK_TOTAL: block_total_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ verif/two_bitmap_free_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for two_bitmap_free_allocator: directed and random requests
// checked against an in-bench predictor of both maps and free counters.
// Depends on tbfa_pkg, the tbfa_req_if/tbfa_rsp_if interfaces and the allocator RTL.
module two_bitmap_free_allocator_tb;
  import tbfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 60;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_e cfg_idx_i;
  logic [BLOCK_TOTAL_W-1:0] cfg_wdata_i;

  tbfa_req_if req_if ();
  tbfa_rsp_if rsp_if ();

  two_bitmap_free_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: index 0 is the inode map, index 1 the block map.
  bit map_bits [2][BLOCK_BITS];
  int unsigned free_cnt [2];
  int unsigned total_reg [2];
  int unsigned alloc_cursor [2];

  req_t request_q [$];
  rsp_t pending_outcomes [$];
  rsp_t got_rsp;
  rsp_t want_rsp;

  int unsigned req_gap;
  int unsigned rsp_hold;
  int unsigned next_hold;
  bit quiet_run;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned requests_done;
  int unsigned responses_seen;
  int unsigned finds_hit;
  int unsigned finds_missed;
  int unsigned cfg_writes;

  task automatic report(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int unsigned s;
    int unsigned size;
    int unsigned tot;
    int unsigned start;
    int unsigned lim;
    int unsigned num;
    int unsigned idx;
    s = r.map_select;
    size = s ? BLOCK_BITS : INODE_BITS;
    tot = total_reg[s];
    start = s ? BLOCK_FIND_START : INODE_FIND_START;
    idx = r.bit_index;
    num = 0;
    requests_done++;
    case (r.mode)
      MODE_FIND: begin
        lim = tot & ~32'd7;
        if (lim > size) lim = size;
        for (int unsigned p = start; p < lim && num == 0; p++) begin
          if (!map_bits[s][p]) num = p + 1;
        end
        if (num != 0) finds_hit++;
        else finds_missed++;
      end
      MODE_SET: if (idx < size) begin
        map_bits[s][idx] = 1'b1;
        if (free_cnt[s] > 0) free_cnt[s] = free_cnt[s] - 1;
      end
      MODE_CLEAR: if (idx < size) begin
        map_bits[s][idx] = 1'b0;
        if (free_cnt[s] < tot) free_cnt[s] = free_cnt[s] + 1;
      end
      default: begin
        free_cnt[s] = (r.count_value > tot) ? tot : r.count_value;
      end
    endcase
    o.found = (num != 0);
    o.free_number = num[NUM_W-1:0];
    o.free_inodes = free_cnt[0][INODE_TOTAL_W-1:0];
    o.free_blocks = free_cnt[1][BLOCK_TOTAL_W-1:0];
    return o;
  endfunction

  task automatic check_response(rsp_t got);
    responses_seen++;
    if (pending_outcomes.size() == 0) begin
      report($sformatf("response %0d arrived with no request outstanding", responses_seen));
    end else begin
      want_rsp = pending_outcomes.pop_front();
      if (got.found !== want_rsp.found)
        report($sformatf("response %0d found %0b, expected %0b",
                         responses_seen, got.found, want_rsp.found));
      if (got.free_number !== want_rsp.free_number)
        report($sformatf("response %0d free_number %0d, expected %0d",
                         responses_seen, got.free_number, want_rsp.free_number));
      if (got.free_inodes !== want_rsp.free_inodes)
        report($sformatf("response %0d free_inodes %0d, expected %0d",
                         responses_seen, got.free_inodes, want_rsp.free_inodes));
      if (got.free_blocks !== want_rsp.free_blocks)
        report($sformatf("response %0d free_blocks %0d, expected %0d",
                         responses_seen, got.free_blocks, want_rsp.free_blocks));
    end
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      req_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) pending_outcomes.push_back(apply_request(req_if.payload));
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.payload <= request_q.pop_front();
          req_gap <= quiet_run ? 0 : $urandom_range(0, 13);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      got_rsp = rsp_if.payload;
      check_response(got_rsp);
      next_hold = quiet_run ? 0 : $urandom_range(0, 13);
      rsp_hold <= next_hold;
      rsp_if.ready <= (next_hold == 0);
    end else if (rsp_hold > 1) begin
      rsp_hold <= rsp_hold - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_hold <= 0;
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic push_req(mode_e m, bit sel, int unsigned idx, int unsigned cval);
    req_t r;
    r.mode = m;
    r.map_select = sel;
    r.bit_index = idx[INDEX_W-1:0];
    r.count_value = cval[BLOCK_TOTAL_W-1:0];
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || req_if.valid || pending_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_total(cfg_idx_e which, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_wdata_i <= value[BLOCK_TOTAL_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_INODE_TOTAL) total_reg[0] = value & ((1 << INODE_TOTAL_W) - 1);
    else total_reg[1] = value & ((1 << BLOCK_TOTAL_W) - 1);
    cfg_writes++;
  endtask

  // Many requests set bits along an allocation frontier per map, or clear below it, so finds land
  // past runs of set bits; the rest are finds, scattered and out-of-range updates and presets.
  task automatic queue_random_items(int unsigned n);
    bit sel;
    int unsigned size;
    int unsigned lo;
    int unsigned lim;
    int unsigned top;
    int unsigned pick;
    int unsigned cval;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(0, 1);
      size = sel ? BLOCK_BITS : INODE_BITS;
      lo = sel ? BLOCK_FIND_START : INODE_FIND_START;
      lim = total_reg[sel] & ~32'd7;
      if (lim > size) lim = size;
      top = (lim > lo + 8) ? lim : lo + 8;
      if (alloc_cursor[sel] >= top) alloc_cursor[sel] = lo;
      cval = $urandom_range(0, 16383);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        alloc_cursor[sel] = $urandom_range(lo, top - 1);
        push_req(MODE_FIND, sel, $urandom_range(0, 8191), cval);
      end else if (pick < 30) begin
        push_req(MODE_SET, sel, alloc_cursor[sel], cval);
        alloc_cursor[sel]++;
      end else if (pick < 55) begin
        push_req(MODE_FIND, sel, $urandom_range(0, 8191), cval);
      end else if (pick < 70) begin
        push_req(MODE_CLEAR, sel, $urandom_range(0, alloc_cursor[sel]), cval);
      end else if (pick < 78) begin
        push_req(MODE_SET, sel, $urandom_range(0, size - 1), cval);
      end else if (pick < 88) begin
        push_req($urandom_range(0, 1) ? MODE_SET : MODE_CLEAR, sel,
                 $urandom_range(0, 8191), cval);
      end else begin
        if ($urandom_range(0, 1)) cval = $urandom_range(0, total_reg[sel] + 4);
        push_req(MODE_PRESET, sel, $urandom_range(0, 8191), cval);
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("two_bitmap_free_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned inode_set [RANDOM_PHASES];
    int unsigned block_set [RANDOM_PHASES];
    inode_set = '{16, 0, 1024, 2047, 8, 1023, 64, 0};
    block_set = '{8, 0, 8192, 16383, 16, 8191, 128, 0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_INODE_TOTAL;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    quiet_run = 1'b0;
    total_reg[0] = INODE_TOTAL_RST;
    total_reg[1] = BLOCK_TOTAL_RST;
    free_cnt[0] = 0;
    free_cnt[1] = 0;
    alloc_cursor[0] = INODE_FIND_START;
    alloc_cursor[1] = BLOCK_FIND_START;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset totals.
    push_req(MODE_FIND, 1'b0, 0, 0);
    push_req(MODE_FIND, 1'b1, 8191, 16383);
    push_req(MODE_SET, 1'b0, 10, 0);
    push_req(MODE_FIND, 1'b0, 0, 0);
    push_req(MODE_PRESET, 1'b0, 0, 16383);
    push_req(MODE_PRESET, 1'b1, 0, 16383);
    push_req(MODE_CLEAR, 1'b0, 10, 0);
    push_req(MODE_SET, 1'b0, 1023, 0);
    push_req(MODE_SET, 1'b0, 1024, 0);
    push_req(MODE_CLEAR, 1'b0, 8191, 0);
    push_req(MODE_SET, 1'b1, 8191, 0);
    push_req(MODE_SET, 1'b1, 1, 0);
    push_req(MODE_FIND, 1'b1, 0, 0);
    push_req(MODE_CLEAR, 1'b1, 1, 0);
    push_req(MODE_PRESET, 1'b0, 8191, 0);
    push_req(MODE_CLEAR, 1'b0, 0, 0);
    wait_idle();

    // Totals that are not whole bytes; the inode total does not reach past the find start.
    write_total(CFG_INODE_TOTAL, 13);
    write_total(CFG_BLOCK_TOTAL, 15);
    push_req(MODE_FIND, 1'b0, 0, 0);
    for (int unsigned b = 1; b < 8; b++) push_req(MODE_SET, 1'b1, b, 0);
    push_req(MODE_FIND, 1'b1, 0, 0);
    push_req(MODE_PRESET, 1'b0, 0, 2047);
    push_req(MODE_CLEAR, 1'b1, 3, 0);
    push_req(MODE_FIND, 1'b1, 0, 0);

    inode_set[RANDOM_PHASES-1] = $urandom_range(0, 2047);
    block_set[RANDOM_PHASES-1] = $urandom_range(0, 16383);
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_total(CFG_INODE_TOTAL, inode_set[ph]);
      write_total(CFG_BLOCK_TOTAL, block_set[ph]);
      quiet_run = ($urandom_range(0, 3) == 0);
      queue_random_items(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report($sformatf("%0d responses never arrived", pending_outcomes.size()));

    $display("Ran %0d requests under %0d register writes; %0d finds hit, %0d found no bit.",
             requests_done, cfg_writes, finds_hit, finds_missed);
    $display("Checked %0d responses, %0d mismatches.", responses_seen, fail_count);
    if (fail_count == 0) begin
      $display("two_bitmap_free_allocator_tb: PASS");
    end else begin
      $display("two_bitmap_free_allocator_tb: FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/tbfa_pkg.sv
src/tbfa_if.sv
src/two_bitmap_free_allocator.sv
verif/two_bitmap_free_allocator_tb.sv
